// File: src/stlm_pkg.sv
package stlm_pkg;

    // Fixed field widths of the item formats.
    localparam int COEFF_W = 16;
    localparam int SUM_W   = 17;
    localparam int EXP_W   = 8;

    // Defaults for the top-level parameters.
    localparam int MAX_TERMS_DEF = 16;
    localparam int EXP_BITS_DEF  = 8;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_START       = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MERGE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
        logic step_last;
    } status_t;

endpackage

// File: src/sparse_term_list_merge_add_unit.sv
// Sparse two-variable polynomial adder. Items on the input stream either load one
// term (coefficient, x exponent, y exponent) into the first or second term list, or
// start a merge; s_tuser selects which. Each list holds up to MAX_TERMS terms and
// should be loaded in descending (x, y) order. A start item merges the two lists in
// that order: terms with equal exponents come out as one term whose coefficient is
// the sum (kept even when it is zero), otherwise the larger term passes unchanged,
// and the remainder of either list follows. The final result of a merge carries
// m_tlast, after which both lists are empty again. When both lists are empty, a
// merge produces one result with term_valid low. A load into a full list is dropped,
// and every result of the following merge then shows the dropped flag. A start item
// puts the block into its merge state, which emits one result per cycle from a single
// head compare and add whenever the output register is free or being read, so a merge
// of lists holding n1 and n2 terms emits between max(n1, n2) and n1 + n2 results, or
// one if both are empty. No new item is taken while a merge runs; a finished result
// waits in the output register while the block takes further loads.
module sparse_term_list_merge_add_unit #(
    parameter int MAX_TERMS = stlm_pkg::MAX_TERMS_DEF,
    parameter int EXP_BITS  = stlm_pkg::EXP_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // coeff[15:0], x_pow[23:16], y_pow[31:24]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // sum_coeff[16:0], out_x_pow[24:17], out_y_pow[32:25]
    output logic [1:0]  m_tuser,   // term_valid[0], dropped[1]
    output logic        m_tlast
);
    import stlm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller sequences loads and merge steps.
    stlm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds both term lists, the merge heads and the output register.
    stlm_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_BITS  (EXP_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

// File: src/stlm_ctrl.sv
module stlm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_tuser,
    input  logic             m_tready,
    input  stlm_pkg::status_t status,
    output stlm_pkg::cmd_t   cmd
);
    import stlm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   step_ok;

    assign accept  = s_tvalid && (state_reg == ST_IDLE);
    assign step_ok = (state_reg == ST_MERGE) && (!status.out_valid || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == OP_START)) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (step_ok && status.step_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        cmd.load_first  = 1'b0;
        cmd.load_second = 1'b0;
        cmd.start       = 1'b0;
        cmd.step        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.load_first  = accept && (s_tuser == OP_LOAD_FIRST);
                cmd.load_second = accept && (s_tuser == OP_LOAD_SECOND);
                cmd.start       = accept && (s_tuser == OP_START);
            end
            ST_MERGE: begin
                cmd.step = step_ok;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/stlm_datapath.sv
module stlm_datapath #(
    parameter int MAX_TERMS = stlm_pkg::MAX_TERMS_DEF,
    parameter int EXP_BITS  = stlm_pkg::EXP_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  stlm_pkg::cmd_t    cmd,
    output stlm_pkg::status_t status,
    input  logic [31:0]       s_tdata,
    output logic [39:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    output logic              m_tvalid,
    input  logic              m_tready
);
    import stlm_pkg::*;

    localparam int EW = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // Term stores, one entry per loaded term.
    logic signed [COEFF_W-1:0] coeff_a_mem [MAX_TERMS];
    logic        [EW-1:0]      x_a_mem     [MAX_TERMS];
    logic        [EW-1:0]      y_a_mem     [MAX_TERMS];
    logic signed [COEFF_W-1:0] coeff_b_mem [MAX_TERMS];
    logic        [EW-1:0]      x_b_mem     [MAX_TERMS];
    logic        [EW-1:0]      y_b_mem     [MAX_TERMS];

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          ovf_reg, ovf_next;

    logic [SUM_W-1:0] sum_reg;
    logic [EXP_W-1:0] ox_reg;
    logic [EXP_W-1:0] oy_reg;
    logic             tv_reg;
    logic             last_reg;
    logic             drop_reg;
    logic             valid_reg;

    logic signed [COEFF_W-1:0] ca_reg, cb_reg;
    logic [EW-1:0]             xa_reg, ya_reg, xb_reg, yb_reg;

    logic [COEFF_W-1:0] in_coeff;
    logic [EW-1:0]      in_x;
    logic [EW-1:0]      in_y;
    logic               full_a;
    logic               full_b;

    logic signed [COEFF_W-1:0] ca, cb;
    logic [EW-1:0]      xa, ya, xb, yb;
    logic               a_avail, b_avail;
    logic               a_gt, a_lt;
    logic               take_a, take_b, take_both;
    logic [SUM_W-1:0]   res_coeff;
    logic [EW-1:0]      res_x, res_y;

    assign in_coeff = s_tdata[15:0];
    assign in_x     = s_tdata[16 +: EW];
    assign in_y     = s_tdata[24 +: EW];
    assign full_a   = (cnt_a_reg == CW'(MAX_TERMS));
    assign full_b   = (cnt_b_reg == CW'(MAX_TERMS));

    always_ff @(posedge aclk) begin
        if (cmd.load_first && !full_a) begin
            coeff_a_mem[cnt_a_reg[IW-1:0]] <= in_coeff;
            x_a_mem[cnt_a_reg[IW-1:0]]     <= in_x;
            y_a_mem[cnt_a_reg[IW-1:0]]     <= in_y;
        end
        if (cmd.load_second && !full_b) begin
            coeff_b_mem[cnt_b_reg[IW-1:0]] <= in_coeff;
            x_b_mem[cnt_b_reg[IW-1:0]]     <= in_x;
            y_b_mem[cnt_b_reg[IW-1:0]]     <= in_y;
        end
    end

    // The head registers read the stores at the next indices, so during a merge
    // they always hold the entries that the current indices point at.
    always_ff @(posedge aclk) begin
        ca_reg <= coeff_a_mem[i_next[IW-1:0]];
        xa_reg <= x_a_mem[i_next[IW-1:0]];
        ya_reg <= y_a_mem[i_next[IW-1:0]];
        cb_reg <= coeff_b_mem[j_next[IW-1:0]];
        xb_reg <= x_b_mem[j_next[IW-1:0]];
        yb_reg <= y_b_mem[j_next[IW-1:0]];
    end

    // Heads of both lists and the merge decision.
    assign ca      = ca_reg;
    assign xa      = xa_reg;
    assign ya      = ya_reg;
    assign cb      = cb_reg;
    assign xb      = xb_reg;
    assign yb      = yb_reg;
    assign a_avail = (i_reg < cnt_a_reg);
    assign b_avail = (j_reg < cnt_b_reg);
    assign a_gt    = ({xa, ya} > {xb, yb});
    assign a_lt    = ({xa, ya} < {xb, yb});

    assign take_both = a_avail && b_avail && !a_gt && !a_lt;
    assign take_a    = a_avail && (!b_avail || a_gt);
    assign take_b    = b_avail && (!a_avail || a_lt);

    always_comb begin
        res_coeff = '0;
        res_x     = '0;
        res_y     = '0;
        if (take_both) begin
            res_coeff = SUM_W'({ca[COEFF_W-1], ca}) + SUM_W'({cb[COEFF_W-1], cb});
            res_x     = xa;
            res_y     = ya;
        end else if (take_a) begin
            res_coeff = SUM_W'({ca[COEFF_W-1], ca});
            res_x     = xa;
            res_y     = ya;
        end else if (take_b) begin
            res_coeff = SUM_W'({cb[COEFF_W-1], cb});
            res_x     = xb;
            res_y     = yb;
        end
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.start) begin
            i_next = '0;
            j_next = '0;
        end else if (cmd.step) begin
            i_next = i_reg + CW'(take_a || take_both);
            j_next = j_reg + CW'(take_b || take_both);
        end
    end

    // The merge ends once the current step brings both head indices up to their counts.
    assign status.step_last = (i_reg + CW'(take_a || take_both) == cnt_a_reg) &&
                              (j_reg + CW'(take_b || take_both) == cnt_b_reg);
    assign status.out_valid = valid_reg;

    always_comb begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        if (cmd.load_first) begin
            if (full_a) begin
                ovf_next = 1'b1;
            end else begin
                cnt_a_next = cnt_a_reg + CW'(1);
            end
        end
        if (cmd.load_second) begin
            if (full_b) begin
                ovf_next = 1'b1;
            end else begin
                cnt_b_next = cnt_b_reg + CW'(1);
            end
        end
        if (cmd.step && status.step_last) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cmd.step) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            sum_reg  <= res_coeff;
            ox_reg   <= EXP_W'(res_x);
            oy_reg   <= EXP_W'(res_y);
            tv_reg   <= a_avail || b_avail;
            last_reg <= status.step_last;
            drop_reg <= ovf_reg;
        end
    end

    assign m_tdata  = {7'd0, oy_reg, ox_reg, sum_reg};
    assign m_tuser  = {drop_reg, tv_reg};
    assign m_tlast  = last_reg;
    assign m_tvalid = valid_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CW'(MAX_TERMS)) && (cnt_b_reg <= CW'(MAX_TERMS)))
        else $error("term count beyond capacity");

    a_step_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (a_avail || b_avail ||
                      (cnt_a_reg == '0 && cnt_b_reg == '0 && i_reg == '0 && j_reg == '0)))
        else $error("merge step with nothing to emit");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.step_last) |=> (cnt_a_reg == '0 && cnt_b_reg == '0 && !ovf_reg))
        else $error("stores not emptied after the last result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (!valid_reg || m_tready))
        else $error("pending result overwritten");
`endif

endmodule
